// ===== sv/page_replacement_policy_engine_assert.svh =====
// Assertion helpers for the page replacement engine.
`ifndef PAGE_REPLACEMENT_POLICY_ENGINE_ASSERT_SVH
`define PAGE_REPLACEMENT_POLICY_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PRPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("prpe assertion failed");

// Next-cycle implication, checked out of reset.
`define PRPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("prpe assertion failed");

`endif

// ===== sv/prpe_pkg.sv =====
`default_nettype none
package prpe_pkg;

    localparam int FRAMES_DEF = 16;

    localparam logic [2:0] POL_FIFO   = 3'd0;
    localparam logic [2:0] POL_LRU    = 3'd1;
    localparam logic [2:0] POL_AGING  = 3'd2;
    localparam logic [2:0] POL_SECOND = 3'd3;
    localparam logic [2:0] POL_LFU    = 3'd4;
    localparam logic [2:0] POL_MFU    = 3'd5;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_FRAMES = 3'd4;

    localparam logic [4:0]  FRAMES_RESET = 5'd16;
    localparam logic [15:0] CNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  page;
        logic        rbit;
        logic [15:0] hist;
        logic [15:0] cnt;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ROTATE,   // shift down from index, op entry lands at tail
        OP_APPEND,   // write at occupancy, grow by one
        OP_SET_REF,
        OP_BUMP,     // saturating count increment plus new stamp
        OP_AGE
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        entry_t   data;
    } store_op_t;

endpackage
`default_nettype wire

// ===== sv/page_replacement_policy_engine.sv =====
// Sequence: a hit passes through SEARCH, HIT, AGE and DONE. A fault passes through SEARCH
//   (skipped when the list is empty), MISS, then SCAN (aging/LFU/MFU) or SECOND (second chance)
//   when it evicts, FILL, AGE and DONE. SEARCH compares frames in order up to the hit or the occupancy.
// Throughput: one item at a time; the next item is accepted only after the result is loaded.
// Reset: synchronous active-low aresetn empties the list, zeroes the access clock and sets
//   policy to FIFO and frames_in_use to 16. No clearing pass.
`default_nettype none
`include "page_replacement_policy_engine_assert.svh"
module page_replacement_policy_engine #(
    parameter int FRAMES = prpe_pkg::FRAMES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // page references
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] page_id
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // [0] fault, [1] evicted, [9:2] evicted_page,
                                        // [14:10] resident_count, [15] zero
);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SEARCH = 9'b000000010,
        S_HIT    = 9'b000000100,
        S_MISS   = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_SECOND = 9'b000100000,
        S_FILL   = 9'b001000000,
        S_AGE    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [2:0] policy_reg;
    logic [4:0] fiu_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= prpe_pkg::POL_FIFO;
            fiu_reg    <= prpe_pkg::FRAMES_RESET;
        end else if (cfg_wr) begin
            if (paddr[2]) fiu_reg <= pwdata[4:0];
            else          policy_reg <= pwdata[2:0];
        end
    end

    assign prdata = paddr[2] ? {27'd0, fiu_reg} : {29'd0, policy_reg};

    // per-item working registers
    logic [7:0]    pg_reg;
    logic [2:0]    pol_reg;
    logic [CW-1:0] limit_reg;
    logic [31:0]   clock_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    prpe_pkg::entry_t best_reg, best_next;
    prpe_pkg::entry_t hold_reg, hold_next;
    logic [CW-1:0] rot_reg, rot_next;
    logic          fault_reg, fault_next;
    logic          ev_reg, ev_next;
    logic [7:0]    evp_reg, evp_next;

    // result register
    logic          m_valid_reg;
    logic [15:0]   m_data_reg;

    // store interface
    prpe_pkg::store_op_t op;
    logic [IW-1:0]       op_idx;
    logic [IW-1:0]       rd_idx;
    prpe_pkg::entry_t    rd_entry;
    prpe_pkg::entry_t    head;
    prpe_pkg::entry_t    new_entry;
    logic [CW-1:0]       occ;
    logic                better;

    // limit clamp: 0 acts as 1, above FRAMES acts as FRAMES
    logic [LW-1:0] fiu_w;
    logic [LW-1:0] limit_w;
    assign fiu_w   = LW'(fiu_reg);
    assign limit_w = (fiu_w == '0) ? LW'(1) :
                     (fiu_w > LW'(FRAMES)) ? LW'(FRAMES) : fiu_w;

    logic          s_acc;
    logic          at_last;
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign at_last  = (CW'(idx_reg) == occ - CW'(1));

    assign new_entry = '{page: pg_reg, rbit: 1'b1, hist: 16'd0, cnt: 16'd1,
                         stamp: clock_reg};

    // FILL reads the victim for its page number
    assign rd_idx = (state_reg == S_FILL) ? best_idx_reg : idx_reg;

    prpe_frame_store #(.FRAMES(FRAMES)) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .op_idx   (op_idx),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .head     (head),
        .occ      (occ)
    );

    prpe_victim_cmp u_cmp (
        .pol    (pol_reg),
        .cand   (rd_entry),
        .best   (best_reg),
        .better (better)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        hold_next     = hold_reg;
        rot_next      = rot_reg;
        fault_next    = fault_reg;
        ev_next       = ev_reg;
        evp_next      = evp_reg;
        op.kind       = prpe_pkg::OP_NONE;
        op.data       = new_entry;
        op_idx        = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    idx_next   = '0;
                    fault_next = 1'b0;
                    ev_next    = 1'b0;
                    evp_next   = 8'd0;
                    state_next = (occ == '0) ? S_MISS : S_SEARCH;
                end
            end
            S_SEARCH: begin
                // one frame compared per cycle
                if (rd_entry.page == pg_reg) begin
                    hold_next  = rd_entry;
                    state_next = S_HIT;
                end else if (at_last) begin
                    state_next = S_MISS;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_HIT: begin
                op_idx = idx_reg;
                unique case (pol_reg)
                    prpe_pkg::POL_LRU: begin
                        op.kind = prpe_pkg::OP_ROTATE;
                        op.data = hold_reg;
                    end
                    prpe_pkg::POL_AGING, prpe_pkg::POL_SECOND: op.kind = prpe_pkg::OP_SET_REF;
                    prpe_pkg::POL_LFU, prpe_pkg::POL_MFU:      op.kind = prpe_pkg::OP_BUMP;
                    default: ;
                endcase
                state_next = S_AGE;
            end
            S_MISS: begin
                fault_next    = 1'b1;
                best_idx_next = '0;
                best_next     = head;
                idx_next      = IW'(1);
                rot_next      = '0;
                if (occ >= limit_reg && occ != '0) begin
                    ev_next = 1'b1;
                    if (pol_reg == prpe_pkg::POL_SECOND) begin
                        state_next = S_SECOND;
                    end else if ((pol_reg == prpe_pkg::POL_AGING ||
                                  pol_reg == prpe_pkg::POL_LFU ||
                                  pol_reg == prpe_pkg::POL_MFU) && occ > CW'(1)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FILL;
                    end
                end else begin
                    state_next = S_FILL;
                end
            end
            S_SCAN: begin
                if (better) begin
                    best_idx_next = idx_reg;
                    best_next     = rd_entry;
                end
                if (at_last) state_next = S_FILL;
                else         idx_next   = idx_reg + IW'(1);
            end
            S_SECOND: begin
                // head with its bit set goes to the tail with the bit cleared
                if (rot_reg < occ && head.rbit) begin
                    op.kind      = prpe_pkg::OP_ROTATE;
                    op_idx       = '0;
                    op.data      = head;
                    op.data.rbit = 1'b0;
                    rot_next     = rot_reg + CW'(1);
                end else begin
                    best_idx_next = '0;
                    state_next    = S_FILL;
                end
            end
            S_FILL: begin
                // eviction plus append is one rotate from the victim
                if (ev_reg) begin
                    evp_next = rd_entry.page;
                    op.kind  = prpe_pkg::OP_ROTATE;
                    op_idx   = best_idx_reg;
                end else begin
                    op.kind = prpe_pkg::OP_APPEND;
                end
                state_next = S_AGE;
            end
            S_AGE: begin
                if (pol_reg == prpe_pkg::POL_AGING) op.kind = prpe_pkg::OP_AGE;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            clock_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc) clock_reg <= clock_reg + 32'd1;
            if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        hold_reg     <= hold_next;
        rot_reg      <= rot_next;
        fault_reg    <= fault_next;
        ev_reg       <= ev_next;
        evp_reg      <= evp_next;
        if (s_acc) begin
            pg_reg    <= s_tdata;
            pol_reg   <= (policy_reg <= prpe_pkg::POL_MFU) ? policy_reg : prpe_pkg::POL_FIFO;
            limit_reg <= CW'(limit_w);
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {1'b0, 5'(occ), evp_reg, ev_reg, fault_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `PRPE_ASSERT_NOW(a_occ_bound, 1'b1, occ <= CW'(FRAMES))
    `PRPE_ASSERT_NOW(a_evict_needs_fault, m_tvalid, !m_tdata[1] || m_tdata[0])
    `PRPE_ASSERT_NOW(a_result_nonempty, m_tvalid, m_tdata[14:10] != 5'd0)
    `PRPE_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready)
    `PRPE_ASSERT_NEXT(a_occ_step, 1'b1, occ == $past(occ) || occ == $past(occ) + CW'(1))
endmodule
`default_nettype wire

// ===== sv/prpe_victim_cmp.sv =====
`default_nettype none
// Shared compare unit: is the candidate a better victim than the current best?
module prpe_victim_cmp (
    input  wire logic [2:0]      pol,
    input  wire prpe_pkg::entry_t cand,
    input  wire prpe_pkg::entry_t best,
    output logic                 better
);
    logic [15:0] a;
    logic [15:0] b;
    logic        lt;
    logic        eq;
    logic        older;

    always_comb begin
        if (pol == prpe_pkg::POL_AGING) begin
            a = cand.hist;
            b = best.hist;
        end else begin
            a = cand.cnt;
            b = best.cnt;
        end
    end

    assign lt    = a < b;
    assign eq    = a == b;
    assign older = cand.stamp < best.stamp;

    always_comb begin
        unique case (pol)
            prpe_pkg::POL_AGING: better = lt;
            prpe_pkg::POL_LFU:   better = lt || (eq && older);
            prpe_pkg::POL_MFU:   better = (!lt && !eq) || (eq && older);
            default:             better = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/prpe_frame_store.sv =====
`default_nettype none
// Ordered frame list: head at index 0, occupancy entries valid.
module prpe_frame_store #(
    parameter int FRAMES = prpe_pkg::FRAMES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire prpe_pkg::store_op_t               op,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] op_idx,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_idx,
    output prpe_pkg::entry_t                       rd_entry,
    output prpe_pkg::entry_t                       head,
    output logic [$clog2(FRAMES + 1)-1:0]          occ
);
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    prpe_pkg::entry_t       mem_reg [FRAMES];
    logic [CW-1:0]          occ_reg;

    assign rd_entry = mem_reg[rd_idx];
    assign head     = mem_reg[0];
    assign occ      = occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (op.kind == prpe_pkg::OP_APPEND) begin
            occ_reg <= occ_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (op.kind)
            prpe_pkg::OP_ROTATE: begin
                for (int k = 0; k < FRAMES; k++) begin
                    if (CW'(k) == occ_reg - CW'(1)) begin
                        mem_reg[k] <= op.data;
                    end else if (k < FRAMES - 1 && CW'(k) >= CW'(op_idx)
                                 && CW'(k) < occ_reg) begin
                        mem_reg[k] <= mem_reg[(k + 1) % FRAMES];
                    end
                end
            end
            prpe_pkg::OP_APPEND: mem_reg[occ_reg[IW-1:0]] <= op.data;
            prpe_pkg::OP_SET_REF: mem_reg[op_idx].rbit <= 1'b1;
            prpe_pkg::OP_BUMP: begin
                if (mem_reg[op_idx].cnt != prpe_pkg::CNT_MAX) begin
                    mem_reg[op_idx].cnt <= mem_reg[op_idx].cnt + 16'd1;
                end
                mem_reg[op_idx].stamp <= op.data.stamp;
            end
            prpe_pkg::OP_AGE: begin
                for (int k = 0; k < FRAMES; k++) begin
                    if (CW'(k) < occ_reg) begin
                        mem_reg[k].hist <= {mem_reg[k].rbit, mem_reg[k].hist[15:1]};
                        mem_reg[k].rbit <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== test/page_replacement_policy_engine_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module page_replacement_policy_engine_test;

    localparam int NFR = 16;
    localparam int LATENCY_PAD = 80;
    localparam int CYCLE_LIMIT = 1200000;

    // result item as it travels on m_tdata, lowest field last
    typedef struct packed {
        logic [4:0] resident_count;
        logic [7:0] evicted_page;
        logic       evicted;
        logic       fault;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;   // [7:0] page_id
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;       // [0] fault, [1] evicted, [9:2] evicted_page, [14:10] resident_count

    page_replacement_policy_engine uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor state: the resident list, head at index 0
    logic [2:0] pol_reg;
    logic [4:0] frames_reg;
    logic [7:0] fr_page [NFR];
    logic fr_rbit [NFR];
    logic [15:0] fr_hist [NFR];
    logic [15:0] fr_cnt [NFR];
    logic [31:0] fr_stamp [NFR];
    int occ;
    logic [31:0] tick;

    outcome_t pending_outcomes[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    longint cycles = 0;

    function automatic void drop_at(int i);
        for (int k = i; k + 1 < occ; k++) begin
            fr_page[k] = fr_page[k+1];
            fr_rbit[k] = fr_rbit[k+1];
            fr_hist[k] = fr_hist[k+1];
            fr_cnt[k] = fr_cnt[k+1];
            fr_stamp[k] = fr_stamp[k+1];
        end
        occ--;
    endfunction

    function automatic void push_tail(logic [7:0] pg, logic rb, logic [15:0] h,
                                      logic [15:0] c, logic [31:0] t);
        if (occ >= NFR) return;
        fr_page[occ] = pg;
        fr_rbit[occ] = rb;
        fr_hist[occ] = h;
        fr_cnt[occ] = c;
        fr_stamp[occ] = t;
        occ++;
    endfunction

    function automatic void to_tail(int i, logic rb);
        logic [7:0] pg;
        logic [15:0] h;
        logic [15:0] c;
        logic [31:0] t;
        pg = fr_page[i]; h = fr_hist[i]; c = fr_cnt[i]; t = fr_stamp[i];
        drop_at(i);
        push_tail(pg, rb, h, c, t);
    endfunction

    function automatic int choose_victim(logic [2:0] p);
        int best;
        best = 0;
        case (p)
            prpe_pkg::POL_AGING: begin
                for (int i = 1; i < occ; i++)
                    if (fr_hist[i] < fr_hist[best]) best = i;
            end
            prpe_pkg::POL_SECOND: begin
                for (int i = 0; i < occ && fr_rbit[0]; i++) to_tail(0, 1'b0);
            end
            prpe_pkg::POL_LFU: begin
                for (int i = 1; i < occ; i++)
                    if (fr_cnt[i] < fr_cnt[best] ||
                        (fr_cnt[i] == fr_cnt[best] && fr_stamp[i] < fr_stamp[best]))
                        best = i;
            end
            prpe_pkg::POL_MFU: begin
                for (int i = 1; i < occ; i++)
                    if (fr_cnt[i] > fr_cnt[best] ||
                        (fr_cnt[i] == fr_cnt[best] && fr_stamp[i] < fr_stamp[best]))
                        best = i;
            end
            default: ;
        endcase
        return best;
    endfunction

    function automatic outcome_t reference_page(logic [7:0] pg);
        outcome_t o;
        logic [2:0] p;
        int lim;
        int hit_at;
        int v;
        o = '0;
        p = (pol_reg <= prpe_pkg::POL_MFU) ? pol_reg : prpe_pkg::POL_FIFO;
        lim = (frames_reg == 0) ? 1 : (frames_reg > NFR ? NFR : frames_reg);
        tick++;
        hit_at = -1;
        for (int i = 0; i < occ; i++)
            if (hit_at < 0 && fr_page[i] == pg) hit_at = i;
        if (hit_at >= 0) begin
            if (p == prpe_pkg::POL_LRU) to_tail(hit_at, fr_rbit[hit_at]);
            else if (p == prpe_pkg::POL_AGING || p == prpe_pkg::POL_SECOND)
                fr_rbit[hit_at] = 1'b1;
            else if (p == prpe_pkg::POL_LFU || p == prpe_pkg::POL_MFU) begin
                if (fr_cnt[hit_at] != prpe_pkg::CNT_MAX) fr_cnt[hit_at]++;
                fr_stamp[hit_at] = tick;
            end
        end else begin
            o.fault = 1'b1;
            if (occ >= lim && occ > 0) begin
                v = choose_victim(p);
                if (v < occ) begin
                    o.evicted = 1'b1;
                    o.evicted_page = fr_page[v];
                    drop_at(v);
                end
            end
            push_tail(pg, 1'b1, 16'h0, 16'h1, tick);
        end
        if (p == prpe_pkg::POL_AGING) begin
            for (int i = 0; i < occ; i++) begin
                fr_hist[i] = fr_hist[i] >> 1;
                if (fr_rbit[i]) begin
                    fr_rbit[i] = 1'b0;
                    fr_hist[i] = fr_hist[i] | 16'h8000;
                end
            end
        end
        o.resident_count = occ[4:0];
        return o;
    endfunction

    // send one page reference, idling first at the current rate;
    // valid stays up after the accept until the next call or wait_idle
    task automatic send_page(logic [7:0] pg);
        outcome_t o;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pg;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        o = reference_page(pg);
        pending_outcomes.insert(pending_outcomes.size(), o);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == prpe_pkg::REG_POLICY) pol_reg = val[2:0];
        else if (addr == prpe_pkg::REG_FRAMES) frames_reg = val[4:0];
        @(posedge aclk);
    endtask

    // drain everything, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    task automatic set_mode(logic [2:0] p, logic [4:0] f);
        wait_idle();
        write_reg(prpe_pkg::REG_POLICY, {29'b0, p});
        write_reg(prpe_pkg::REG_FRAMES, {27'b0, f});
    endtask

    // receiver: random stall, with an optional long hold-off
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[14:0];
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want || m_tdata[15] !== 1'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp f=%b e=%b pg=%0d n=%0d got f=%b e=%b pg=%0d n=%0d",
                                 want.fault, want.evicted, want.evicted_page,
                                 want.resident_count, got.fault, got.evicted,
                                 got.evicted_page, got.resident_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL page_replacement_policy_engine");
            $finish;
        end
    end

    // extremes, repeats, every policy incl. unused codes, limit 0 and 31
    task automatic test_directed();
        logic [2:0] p;
        for (int k = 0; k < 8; k++) begin
            p = 3'(k);
            set_mode(p, (k == 6) ? 5'd0 : (k == 7 ? 5'd31 : 5'd2));
            send_page(8'h00); send_page(8'hFF); send_page(8'h00);
            send_page(8'h55); send_page(8'hAA); send_page(8'h00);
        end
        // shrink the limit while full: one eviction per fault
        set_mode(prpe_pkg::POL_FIFO, 5'd16);
        for (int i = 0; i < 16; i++) send_page(8'(i * 17));
        set_mode(prpe_pkg::POL_LRU, 5'd1);
        send_page(8'h77); send_page(8'h00);
    endtask

    // random references over a small page pool so hits are common
    task automatic test_random(int n, int pool);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) send_page(8'($urandom));
            else send_page(8'($urandom_range(pool - 1)));
        end
    endtask

    task automatic test_policies();
        logic [4:0] lims [5] = '{5'd1, 5'd16, 5'd4, 5'd7, 5'd12};
        for (int k = 0; k < 18; k++) begin
            set_mode(3'($urandom_range(7)), lims[k % 5]);
            case (k % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 88; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 88; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            test_random(85, 6 + $urandom_range(20));
        end
        send_idle_pct = 0; recv_stall_pct = 0;
    endtask

    // LFU with one hot page driven far up to exercise the counts, then MFU on a small pool
    task automatic test_hot_page();
        set_mode(prpe_pkg::POL_LFU, 5'd3);
        for (int i = 0; i < 120; i++) send_page(($urandom_range(2) == 0) ? 8'd9 : 8'($urandom));
        set_mode(prpe_pkg::POL_MFU, 5'd3);
        test_random(60, 5);
    endtask

    // receiver blocked for a long time while the sender keeps offering items
    task automatic test_backpressure();
        set_mode(prpe_pkg::POL_SECOND, 5'd5);
        hold_cycles = 600;
        test_random(40, 8);
    endtask

    initial begin
        pol_reg = prpe_pkg::POL_FIFO;
        frames_reg = prpe_pkg::FRAMES_RESET;
        occ = 0;
        tick = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_policies();
        test_hot_page();
        test_backpressure();
        wait_idle();
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS page_replacement_policy_engine");
        else
            $display("FAIL page_replacement_policy_engine");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/prpe_pkg.sv
sv/prpe_victim_cmp.sv
sv/prpe_frame_store.sv
sv/page_replacement_policy_engine.sv
test/page_replacement_policy_engine_test.sv
